>>> rtl/ssrp_pkg.sv
// Package of shared types, constants and codes for the sensor status record parser.
`default_nettype none

package ssrp_pkg;

    // Number of value bytes gathered per record; never more than three are stored.
    localparam int VALUE_BYTES  = 3;
    localparam int VALUE_STORED = (VALUE_BYTES < 3) ? VALUE_BYTES : 3;

    // Number of configured property registers.
    localparam int NUM_PROPS = 6;

    // Header byte field masks.
    localparam logic [7:0] FORMAT_BIT     = 8'h01;
    localparam logic [7:0] SHORT_LEN_BITS = 8'h1E;
    localparam logic [7:0] SHORT_ID_BITS  = 8'hE0;
    localparam logic [7:0] LONG_LEN_BITS  = 8'hFE;

    // Register indexes on the configuration port.
    localparam logic [7:0] REG_PRESENCE = 8'd0;
    localparam logic [7:0] REG_LIGHT    = 8'd1;
    localparam logic [7:0] REG_POWER    = 8'd2;
    localparam logic [7:0] REG_CURRENT  = 8'd3;
    localparam logic [7:0] REG_VOLTAGE  = 8'd4;
    localparam logic [7:0] REG_ENERGY   = 8'd5;

    // Reset values of the property registers and the value length each expects.
    localparam logic [15:0] PROP_RESET [NUM_PROPS] =
        '{16'd77, 16'd78, 16'd82, 16'd87, 16'd89, 16'd106};
    localparam logic [7:0] EXPECTED_LEN [NUM_PROPS] =
        '{8'd1, 8'd3, 8'd3, 8'd2, 8'd2, 8'd3};

    // Record class codes.
    typedef enum logic [3:0] {
        CLASS_PRESENCE  = 4'd0,
        CLASS_LIGHT     = 4'd1,
        CLASS_POWER     = 4'd2,
        CLASS_CURRENT   = 4'd3,
        CLASS_VOLTAGE   = 4'd4,
        CLASS_ENERGY    = 4'd5,
        CLASS_UNKNOWN   = 4'd6,
        CLASS_BADLEN    = 4'd7,
        CLASS_TRUNCATED = 4'd8
    } t_class;

    // Property register bank.
    typedef logic [15:0] t_prop_bank [NUM_PROPS];

    // One parsed record as handed to the output register.
    typedef struct packed {
        t_class      record_class;
        logic [15:0] property_number;
        logic [23:0] record_value;
        logic [7:0]  value_length;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ssrp_cfg_regs.sv
// Property id register bank written through the configuration port.
`default_nettype none

module ssrp_cfg_regs
    import ssrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic [7:0]  i_wr_index,
    input  wire logic [15:0] i_wr_data,
    output t_prop_bank       o_props
);

    t_prop_bank r_props;

    // Each register loads when its index is written; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PROPS; k++) begin
                r_props[k] <= PROP_RESET[k];
            end
        end else if (i_wr_en) begin
            for (int k = 0; k < NUM_PROPS; k++) begin
                if (i_wr_index == 8'(k)) begin
                    r_props[k] <= i_wr_data;
                end
            end
        end
    end

    assign o_props = r_props;

endmodule

`default_nettype wire

>>> rtl/ssrp_parser.sv
// Record parser: running parse state, one byte per step, and record classification.
`default_nettype none

module ssrp_parser
    import ssrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  t_prop_bank      i_props,
    output logic            o_emit,
    output t_result         o_result
);

    typedef enum logic [1:0] {
        PH_HEADER0 = 2'd0,
        PH_HEADER1 = 2'd1,
        PH_HEADER2 = 2'd2,
        PH_VALUE   = 2'd3
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic        r_long,       n_long;
    logic [7:0]  r_decl_len,   n_decl_len;
    logic [7:0]  r_bytes_seen, n_bytes_seen;
    logic [15:0] r_prop_acc,   n_prop_acc;
    logic [23:0] r_value_acc,  n_value_acc;

    logic        done;
    logic        found;
    t_class      match_class;

    // Next parse state for the byte in hand.
    always_comb begin
        n_phase      = r_phase;
        n_long       = r_long;
        n_decl_len   = r_decl_len;
        n_bytes_seen = r_bytes_seen;
        n_prop_acc   = r_prop_acc;
        n_value_acc  = r_value_acc;
        done         = 1'b0;
        unique case (r_phase)
            PH_HEADER1: begin
                if (r_long) begin
                    n_prop_acc = {8'd0, i_data_byte};
                    n_phase    = PH_HEADER2;
                end else begin
                    n_prop_acc = r_prop_acc | {5'd0, i_data_byte, 3'd0};
                    n_phase    = PH_VALUE;
                end
            end
            PH_HEADER2: begin
                n_prop_acc = r_prop_acc | {i_data_byte, 8'd0};
                n_phase    = PH_VALUE;
            end
            PH_VALUE: begin
                for (int k = 0; k < VALUE_STORED; k++) begin
                    if (r_bytes_seen == 8'(k)) begin
                        n_value_acc[8*k +: 8] = r_value_acc[8*k +: 8] | i_data_byte;
                    end
                end
                n_bytes_seen = r_bytes_seen + 8'd1;
                done         = (n_bytes_seen >= r_decl_len);
            end
            PH_HEADER0: begin
                n_long = i_data_byte[0];
                if ((i_data_byte & FORMAT_BIT) != 8'd0) begin
                    n_decl_len = ((i_data_byte & LONG_LEN_BITS) >> 1) + 8'd1;
                    n_prop_acc = 16'd0;
                end else begin
                    n_decl_len = ((i_data_byte & SHORT_LEN_BITS) >> 1) + 8'd1;
                    n_prop_acc = {8'd0, (i_data_byte & SHORT_ID_BITS) >> 5};
                end
                n_bytes_seen = 8'd0;
                n_value_acc  = 24'd0;
                n_phase      = PH_HEADER1;
            end
            default: begin
                n_phase = PH_HEADER0;
            end
        endcase
        // Either a finished record or the message end sends the parser back to a header.
        if (done || i_last_byte) begin
            n_phase = PH_HEADER0;
        end
    end

    // Compare the finished id against the registers; the lowest matching index decides.
    always_comb begin
        found       = 1'b0;
        match_class = CLASS_UNKNOWN;
        for (int k = 0; k < NUM_PROPS; k++) begin
            if (!found && i_props[k] == n_prop_acc) begin
                found       = 1'b1;
                match_class = (n_decl_len == EXPECTED_LEN[k]) ? t_class'(4'(k))
                                                              : CLASS_BADLEN;
            end
        end
    end

    // Result word for this byte, if it ends a record or a message.
    always_comb begin
        o_emit                   = done || i_last_byte;
        o_result.record_class    = done ? match_class : CLASS_TRUNCATED;
        o_result.property_number = n_prop_acc;
        o_result.record_value    = n_value_acc;
        o_result.value_length    = n_decl_len;
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER0;
            r_long       <= 1'b0;
            r_decl_len   <= 8'd0;
            r_bytes_seen <= 8'd0;
            r_prop_acc   <= 16'd0;
            r_value_acc  <= 24'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_long       <= n_long;
            r_decl_len   <= n_decl_len;
            r_bytes_seen <= n_bytes_seen;
            r_prop_acc   <= n_prop_acc;
            r_value_acc  <= n_value_acc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sensor_status_record_parser_core.sv
// Top level of the sensor status record parser: input register, parser and result register.
`default_nettype none

// The block takes the sensor data bytes of a sensor status message, one word per cycle
// while the byte channel is not held off, and returns one result word for each
// marshalled record (short or long header) that completes, or a truncated result when
// the message ends inside a record. Bytes are accepted at one per clock, with no gaps
// while the byte channel is not held off; a byte passes an input register, the header
// and value parse plus the compare against the six property id registers, and a result
// register, from which the result word shows on the result port. The rate is set by the
// single parse step between the two registers, which updates the running record state
// once per byte. The byte channel is held off only while both registers hold a word and
// the result port is stalled. The property id registers may be written only while no byte is in flight.

module sensor_status_record_parser_core
    import ssrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [15:0] i_source_address,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_record_class,
    output logic [15:0]      o_property_number,
    output logic [23:0]      o_record_value,
    output logic [7:0]       o_value_length,
    output logic [15:0]      o_sender_address,
    // Configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_in_src;

    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_out_src;

    logic        advance;
    logic        emit;
    t_result     result;
    t_prop_bank  props;

    // The held byte moves on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
            r_in_src  <= i_source_address;
        end
    end

    ssrp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_props    (props)
    );

    ssrp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .i_props     (props),
        .o_emit      (emit),
        .o_result    (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out     <= result;
            r_out_src <= r_in_src;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_record_class    = r_out.record_class;
    assign o_property_number = r_out.property_number;
    assign o_record_value    = r_out.record_value;
    assign o_value_length    = r_out.value_length;
    assign o_sender_address  = r_out_src;

endmodule

`default_nettype wire

>>> rtl/ssrp_checker.sv
// Port-level checker for the sensor status record parser, bound to the top level.
`default_nettype none

module ssrp_checker
    import ssrp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  o_record_class,
    input wire logic [15:0] o_property_number,
    input wire logic [23:0] o_record_value,
    input wire logic [7:0]  o_value_length
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_record_class)
            && $stable(o_property_number) && $stable(o_record_value)
            && $stable(o_value_length))
        else $error("result word changed while stalled");

    // With the result register empty, the byte channel is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("byte channel stalled with no result pending");

    // Declared lengths are one-based, and class codes stop at truncated.
    a_class_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_value_length != 8'd0 && o_value_length <= 8'd128
            && o_record_class <= 4'(CLASS_TRUNCATED))
        else $error("result class or length out of range");

    // A matched class carries exactly the length that property expects.
    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_record_class != 4'(CLASS_PRESENCE) || o_value_length == EXPECTED_LEN[0])
         && (o_record_class != 4'(CLASS_LIGHT)    || o_value_length == EXPECTED_LEN[1])
         && (o_record_class != 4'(CLASS_POWER)    || o_value_length == EXPECTED_LEN[2])
         && (o_record_class != 4'(CLASS_CURRENT)  || o_value_length == EXPECTED_LEN[3])
         && (o_record_class != 4'(CLASS_VOLTAGE)  || o_value_length == EXPECTED_LEN[4])
         && (o_record_class != 4'(CLASS_ENERGY)   || o_value_length == EXPECTED_LEN[5]))
        else $error("matched class with unexpected value length");

endmodule

bind sensor_status_record_parser_core ssrp_checker u_ssrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_record_class    (o_record_class),
    .o_property_number (o_property_number),
    .o_record_value    (o_record_value),
    .o_value_length    (o_value_length)
);

`default_nettype wire
